// ===== rtl/fas_pkg.sv =====
package fas_pkg;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHIFT       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_BYTES = 2'd2;

    localparam int SHIFT_W   = 3;
    localparam int FRAMES_W  = 16;
    localparam int POS_W     = 21;
    localparam int BYTE_W    = 8;
    localparam int RADDR_W   = 20;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;

    // Wide enough to hold any store depth the block supports, plus one.
    localparam int WIDE_W = 25;

    localparam logic [POS_W-1:0]    IMAGE_BYTES_RST = 21'd1048576;
    localparam logic [FRAMES_W-1:0] FRAMES_RST      = 16'd1;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [FRAMES_W-1:0] frames_counted;
        logic                release_pulse;
        logic                capture_done;
        logic [BYTE_W-1:0]   read_data;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic              wr;
        logic              clear;
        logic [BYTE_W-1:0] value;
    } t_store_ctl;

endpackage

// ===== rtl/frame_accumulator_shift_sum.sv =====
// Multi-frame image integration into a byte store of IMAGE_DEPTH entries.
// Input channel s_axis: tuser carries the command (start, data byte, read),
// tlast marks the last byte of a camera buffer, and tdata carries the byte,
// the read address and the buffer flags. Output channel m_axis returns one
// result per accepted item: the read byte, the done flag, the release pulse
// and the frame count. The user must write registers through the i_cfg port
// only while the block is idle; the block itself does not enforce this.
// Each input transfer is registered in stage one, where the synchronous store
// read completes and the add and write-back are made, with the write data
// forwarded to a read of the same entry; its result then enters the output queue.
// Throughput is one item per cycle while no clearing pass runs and the output
// queue has room, set by the single read-modify-write of the store per item.
// Reset and every start command run a clearing pass that writes zero to one
// store entry per cycle, over all IMAGE_DEPTH entries, with s_axis_tready low.
// Results wait in a three-entry output queue; when m_axis_tready is held low
// the queue fills and s_axis_tready drops until results are taken.
module frame_accumulator_shift_sum #(
    parameter int IMAGE_DEPTH = 1048576
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // data_byte, read_address, end_of_stream, frame_end, transfer_failed, any_flag_set
    input  logic [fas_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command
    input  logic [fas_pkg::CMD_W-1:0]         s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_data, capture_done, release_pulse, frames_counted, zero fill
    output logic [fas_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [fas_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [fas_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (IMAGE_DEPTH > 1) ? $clog2(IMAGE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(IMAGE_DEPTH - 1);
    localparam logic [fas_pkg::WIDE_W-1:0] DEPTH_W = fas_pkg::WIDE_W'(IMAGE_DEPTH);

    logic [fas_pkg::SHIFT_W-1:0]  r_shift;
    logic [fas_pkg::FRAMES_W-1:0] r_target;
    logic [fas_pkg::POS_W-1:0]    r_img_bytes;

    logic [fas_pkg::POS_W-1:0]    r_wp, n_wp;
    logic [fas_pkg::FRAMES_W-1:0] r_fc, n_fc;
    logic                         r_done, n_done;
    logic                         r_clearing, n_clearing;
    logic [AW-1:0]                r_clr_addr, n_clr_addr;

    logic                         r_s1_valid;
    logic                         r_s1_rd_ok;
    fas_pkg::t_result             r_s1_res;

    fas_pkg::t_result             r_fifo [3];
    logic [1:0]                   r_wr_ptr;
    logic [1:0]                   r_rd_ptr;
    logic [1:0]                   r_cnt;

    logic                         w_accept;
    logic                         w_pop;
    logic [fas_pkg::CMD_W-1:0]    w_cmd;
    logic [fas_pkg::BYTE_W-1:0]   w_byte;
    logic [fas_pkg::RADDR_W-1:0]  w_raddr;
    logic                         w_eos;
    logic                         w_fend;
    logic                         w_fail;
    logic                         w_flagged;
    logic [fas_pkg::WIDE_W-1:0]   w_wp_wide;
    logic [fas_pkg::WIDE_W-1:0]   w_ra_wide;
    logic [fas_pkg::FRAMES_W-1:0] w_fc_inc;
    logic                         w_release;
    logic                         w_rd_ok;
    logic [AW-1:0]                w_addr;
    fas_pkg::t_store_ctl          w_ctl;
    logic [fas_pkg::BYTE_W-1:0]   w_rdata;
    fas_pkg::t_result             w_res;

    assign w_cmd     = s_axis_tuser;
    assign w_byte    = s_axis_tdata[7:0];
    assign w_raddr   = s_axis_tdata[27:8];
    assign w_eos     = s_axis_tdata[28];
    assign w_fend    = s_axis_tdata[29];
    assign w_fail    = s_axis_tdata[30];
    assign w_flagged = s_axis_tdata[31];

    assign w_wp_wide = fas_pkg::WIDE_W'(r_wp);
    assign w_ra_wide = fas_pkg::WIDE_W'(w_raddr);
    assign w_fc_inc  = (r_fc != fas_pkg::FRAMES_MAX) ? r_fc + 16'd1 : r_fc;

    assign s_axis_tready = !r_clearing && ((3'(r_cnt) + 3'(r_s1_valid)) < 3'd3);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_wp       = r_wp;
        n_fc       = r_fc;
        n_done     = r_done;
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        w_release  = 1'b0;
        w_rd_ok    = 1'b0;
        w_addr     = w_wp_wide[AW-1:0];
        w_ctl.valid = w_accept;
        w_ctl.wr    = 1'b0;
        w_ctl.clear = r_clearing;
        w_ctl.value = w_byte >> r_shift;

        if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + AW'(1);
            end
        end

        if (w_accept) begin
            unique case (w_cmd)
                fas_pkg::CMD_START: begin
                    n_wp       = '0;
                    n_fc       = '0;
                    n_done     = 1'b0;
                    n_clearing = 1'b1;
                    n_clr_addr = '0;
                end
                fas_pkg::CMD_DATA: begin
                    if (w_eos) begin
                        w_release = s_axis_tlast;
                    end else if (!r_done && w_flagged) begin
                        if ((r_wp < r_img_bytes) && (w_wp_wide < DEPTH_W)) begin
                            w_ctl.wr = 1'b1;
                            n_wp     = r_wp + 21'd1;
                        end
                        if (s_axis_tlast && (w_fend || w_fail)) begin
                            n_fc = w_fc_inc;
                            n_wp = '0;
                            if (w_fc_inc >= r_target) begin
                                n_done    = 1'b1;
                                w_release = 1'b1;
                            end
                        end
                    end
                end
                fas_pkg::CMD_READ: begin
                    w_addr  = w_ra_wide[AW-1:0];
                    w_rd_ok = w_ra_wide < DEPTH_W;
                end
                default: begin
                end
            endcase
        end
    end

    fas_store #(
        .IMAGE_DEPTH(IMAGE_DEPTH),
        .AW         (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_addr     (w_addr),
        .i_clr_addr (r_clr_addr),
        .o_rdata    (w_rdata)
    );

    always_comb begin
        w_res           = r_s1_res;
        w_res.read_data = r_s1_rd_ok ? w_rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_target    <= fas_pkg::FRAMES_RST;
            r_img_bytes <= fas_pkg::IMAGE_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fas_pkg::CFG_SHIFT:       r_shift     <= i_cfg_data[fas_pkg::SHIFT_W-1:0];
                fas_pkg::CFG_FRAMES:      r_target    <= i_cfg_data[fas_pkg::FRAMES_W-1:0];
                fas_pkg::CFG_IMAGE_BYTES: r_img_bytes <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_fc       <= '0;
            r_done     <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_wp       <= n_wp;
            r_fc       <= n_fc;
            r_done     <= n_done;
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_rd_ok                 <= w_rd_ok;
        r_s1_res.frames_counted    <= n_fc;
        r_s1_res.release_pulse     <= w_release;
        r_s1_res.capture_done      <= n_done;
        r_s1_res.read_data         <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wr_ptr <= (r_wr_ptr == 2'd2) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'd2) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            r_cnt <= r_cnt + 2'(r_s1_valid) - 2'(w_pop);
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = fas_pkg::OUT_DATA_W'(r_fifo[r_rd_ptr]);

endmodule

// ===== rtl/fas_store.sv =====
module fas_store #(
    parameter int IMAGE_DEPTH = 1048576,
    parameter int AW = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fas_pkg::t_store_ctl           i_ctl,
    input  logic [AW-1:0]                 i_addr,
    input  logic [AW-1:0]                 i_clr_addr,
    output logic [fas_pkg::BYTE_W-1:0]    o_rdata
);

    logic [fas_pkg::BYTE_W-1:0] r_mem [IMAGE_DEPTH];
    logic [fas_pkg::BYTE_W-1:0] r_q;
    logic [fas_pkg::BYTE_W-1:0] r_fwd_data;
    logic                       r_fwd;
    logic                       r_s1_valid;
    logic                       r_s1_wr;
    logic [AW-1:0]              r_s1_addr;
    logic [fas_pkg::BYTE_W-1:0] r_s1_value;
    logic [fas_pkg::BYTE_W-1:0] w_cur;
    logic [fas_pkg::BYTE_W-1:0] w_sum;
    logic                       w_wr;

    assign w_cur   = r_fwd ? r_fwd_data : r_q;
    assign w_sum   = w_cur + r_s1_value;
    assign w_wr    = r_s1_valid && r_s1_wr;
    assign o_rdata = w_cur;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_s1_addr] <= w_sum;
        end else if (i_ctl.clear) begin
            r_mem[i_clr_addr] <= '0;
        end
        r_q <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        r_fwd      <= w_wr && (r_s1_addr == i_addr);
        r_fwd_data <= w_sum;
        r_s1_wr    <= i_ctl.wr;
        r_s1_addr  <= i_addr;
        r_s1_value <= i_ctl.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.valid;
        end
    end

endmodule

// ===== rtl/fas_checker.sv =====
module fas_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [fas_pkg::CMD_W-1:0]     s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fas_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // Reset starts the clearing pass, so no transfer is taken right after it.
    a_reset_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_start_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == fas_pkg::CMD_START)
        |=> !s_axis_tready)
        else $error("input ready while the store is being cleared");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("no result two cycles after an input transfer");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind frame_accumulator_shift_sum fas_checker u_fas_checker (.*);

// ===== tb/sv/frame_accumulator_shift_sum_tb.sv =====
`timescale 1ns / 1ps

module frame_accumulator_shift_sum_tb;

    localparam int TB_DEPTH = 64;
    localparam int TB_AW = $clog2(TB_DEPTH);
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [fas_pkg::CMD_W-1:0]   cmd;
        logic [fas_pkg::BYTE_W-1:0]  pixel;
        logic [fas_pkg::RADDR_W-1:0] addr;
        logic                        last;
        logic                        eos;
        logic                        fend;
        logic                        fail;
        logic                        flagged;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [fas_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [fas_pkg::CMD_W-1:0] s_axis_tuser = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [fas_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [fas_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [fas_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    frame_accumulator_shift_sum #(
        .IMAGE_DEPTH(TB_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted block state and register copies.
    logic [fas_pkg::BYTE_W-1:0]   image_mem [TB_DEPTH];
    logic [fas_pkg::POS_W-1:0]    write_pos = '0;
    logic [fas_pkg::FRAMES_W-1:0] frame_cnt = '0;
    logic                         pred_done = 1'b0;
    logic [fas_pkg::SHIFT_W-1:0]  shift_reg = '0;
    logic [fas_pkg::FRAMES_W-1:0] target_reg = fas_pkg::FRAMES_RST;
    logic [fas_pkg::POS_W-1:0]    image_bytes_reg = fas_pkg::IMAGE_BYTES_RST;

    t_item            item_q[$];
    fas_pkg::t_result expected_q[$];
    t_item            cur_item;
    logic             quiet = 1'b0;
    logic             hold_done = 1'b0;
    int               tx_gap;
    int               rx_wait;
    int               hold_left = 0;
    int               errors = 0;
    int               n_results = 0;
    int               n_frames = 0;
    int               n_captures = 0;
    int               n_clears = 0;
    int               n_settings = 0;
    int               cycles = 0;
    int               cap_len = 8;

    initial begin
        for (int i = 0; i < TB_DEPTH; i++) begin
            image_mem[i] = '0;
        end
    end

    task automatic integrate_item(input t_item it);
        fas_pkg::t_result r;
        r = '0;
        case (it.cmd)
            fas_pkg::CMD_START: begin
                for (int i = 0; i < TB_DEPTH; i++) begin
                    image_mem[i] = '0;
                end
                write_pos = '0;
                frame_cnt = '0;
                pred_done = 1'b0;
                n_clears++;
            end
            fas_pkg::CMD_DATA: begin
                if (it.eos) begin
                    r.release_pulse = it.last;
                end else if (!pred_done && it.flagged) begin
                    if (write_pos < image_bytes_reg && write_pos < TB_DEPTH) begin
                        image_mem[write_pos[TB_AW-1:0]] =
                            image_mem[write_pos[TB_AW-1:0]] + (it.pixel >> shift_reg);
                        write_pos = write_pos + 21'd1;
                    end
                    if (it.last && (it.fend || it.fail)) begin
                        if (frame_cnt != fas_pkg::FRAMES_MAX) begin
                            frame_cnt = frame_cnt + 16'd1;
                        end
                        write_pos = '0;
                        n_frames++;
                        if (frame_cnt >= target_reg) begin
                            pred_done = 1'b1;
                            r.release_pulse = 1'b1;
                            n_captures++;
                        end
                    end
                end
            end
            fas_pkg::CMD_READ: begin
                if (it.addr < TB_DEPTH) begin
                    r.read_data = image_mem[it.addr[TB_AW-1:0]];
                end
            end
            default: begin
            end
        endcase
        r.capture_done = pred_done;
        r.frames_counted = frame_cnt;
        expected_q.push_back(r);
    endtask

    // Sender: offers queued items, with a random gap after each transfer unless quiet is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                integrate_item(cur_item);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (item_q.size() != 0) begin
                cur_item = item_q.pop_front();
                s_axis_tdata <= {cur_item.flagged, cur_item.fail, cur_item.fend,
                                 cur_item.eos, cur_item.addr, cur_item.pixel};
                s_axis_tuser <= cur_item.cmd;
                s_axis_tlast <= cur_item.last;
                s_axis_tvalid <= 1'b1;
                tx_gap = quiet ? 0 : $urandom_range(0, 3);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off once 200 results have arrived.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_results >= 200) begin
            hold_left <= 90;
            hold_done <= 1'b1;
        end
    end

    // Receiver: checks each result and stalls at random.
    always @(posedge i_clk) begin
        fas_pkg::t_result exp_r;
        fas_pkg::t_result got_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_r = fas_pkg::t_result'(m_axis_tdata[25:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r.read_data !== exp_r.read_data) begin
                        $display("%0t: read_data expected %0d actual %0d",
                                 $time, exp_r.read_data, got_r.read_data);
                        errors++;
                    end
                    if (got_r.capture_done !== exp_r.capture_done) begin
                        $display("%0t: capture_done expected %0d actual %0d",
                                 $time, exp_r.capture_done, got_r.capture_done);
                        errors++;
                    end
                    if (got_r.release_pulse !== exp_r.release_pulse) begin
                        $display("%0t: release_pulse expected %0d actual %0d",
                                 $time, exp_r.release_pulse, got_r.release_pulse);
                        errors++;
                    end
                    if (got_r.frames_counted !== exp_r.frames_counted) begin
                        $display("%0t: frames_counted expected %0d actual %0d",
                                 $time, exp_r.frames_counted, got_r.frames_counted);
                        errors++;
                    end
                    if (m_axis_tdata[fas_pkg::OUT_DATA_W-1:26] !== '0) begin
                        $display("%0t: zero fill expected 0 actual %h",
                                 $time, m_axis_tdata[fas_pkg::OUT_DATA_W-1:26]);
                        errors++;
                    end
                end
                n_results++;
                rx_wait = quiet ? 0 : $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
            $display("frame_accumulator_shift_sum verification failed");
            $finish;
        end
    end

    function automatic bit rnd_bit();
        return 1'($urandom);
    endfunction

    function automatic t_item mk_item(input logic [fas_pkg::CMD_W-1:0] cmd, input int pixel,
                                      input int addr, input bit last, input bit eos,
                                      input bit fend, input bit fail, input bit flagged);
        t_item it;
        it.cmd = cmd;
        it.pixel = pixel[fas_pkg::BYTE_W-1:0];
        it.addr = addr[fas_pkg::RADDR_W-1:0];
        it.last = last;
        it.eos = eos;
        it.fend = fend;
        it.fail = fail;
        it.flagged = flagged;
        return it;
    endfunction

    task automatic write_reg(input logic [fas_pkg::CFG_ADDR_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value[fas_pkg::CFG_DATA_W-1:0];
        case (idx)
            fas_pkg::CFG_SHIFT:       shift_reg = value[fas_pkg::SHIFT_W-1:0];
            fas_pkg::CFG_FRAMES:      target_reg = value[fas_pkg::FRAMES_W-1:0];
            fas_pkg::CFG_IMAGE_BYTES: image_bytes_reg = value[fas_pkg::POS_W-1:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic configure(input int shift, input int target, input int img);
        wait_idle();
        write_reg(fas_pkg::CFG_SHIFT, shift);
        write_reg(fas_pkg::CFG_FRAMES, target);
        write_reg(fas_pkg::CFG_IMAGE_BYTES, img);
        n_settings++;
    endtask

    task automatic push_read(input int addr);
        item_q.push_back(mk_item(fas_pkg::CMD_READ, $urandom, addr, rnd_bit(), rnd_bit(),
                                 rnd_bit(), rnd_bit(), rnd_bit()));
    endtask

    task automatic push_buffer(input int len, input bit eos, input bit fend,
                               input bit fail, input bit flagged);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_read($urandom_range(0, TB_DEPTH - 1));
            end
            item_q.push_back(mk_item(fas_pkg::CMD_DATA, $urandom, $urandom, k == len - 1,
                                     eos, fend, fail, flagged));
        end
    endtask

    task automatic push_frame();
        int remaining;
        int blen;
        int ends;
        remaining = $urandom_range(1, cap_len);
        while (remaining > 0) begin
            blen = $urandom_range(1, (remaining < 6) ? remaining : 6);
            remaining -= blen;
            if (remaining == 0) begin
                ends = $urandom_range(1, 3);
                push_buffer(blen, 1'b0, ends[0], ends[1], 1'b1);
            end else begin
                push_buffer(blen, 1'b0, 1'b0, 1'b0, 1'b1);
            end
        end
    endtask

    task automatic fill_random(input int count);
        int pick;
        item_q.push_back(mk_item(fas_pkg::CMD_START, $urandom, $urandom, rnd_bit(),
                                 rnd_bit(), rnd_bit(), rnd_bit(), rnd_bit()));
        while (item_q.size() < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                push_frame();
            end else if (pick < 70) begin
                push_read($urandom_range(0, TB_DEPTH + 3));
            end else if (pick < 78) begin
                push_buffer($urandom_range(1, 3), 1'b0, rnd_bit(), rnd_bit(), 1'b0);
            end else if (pick < 84) begin
                push_buffer($urandom_range(1, 3), 1'b1, rnd_bit(), rnd_bit(), rnd_bit());
            end else if (pick < 88) begin
                item_q.push_back(mk_item(fas_pkg::CMD_W'($urandom_range(0, 3)), $urandom,
                                         $urandom, rnd_bit(), rnd_bit(), rnd_bit(),
                                         rnd_bit(), rnd_bit()));
            end else if (pick < 94) begin
                item_q.push_back(mk_item(fas_pkg::CMD_START, $urandom, $urandom, rnd_bit(),
                                         rnd_bit(), rnd_bit(), rnd_bit(), rnd_bit()));
            end else begin
                push_read($urandom);
            end
        end
    endtask

    initial begin
        int img;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(0, 2, 8);
        push_read(0);
        push_read(20'hFFFFF);
        item_q.push_back(mk_item(fas_pkg::CMD_NONE, 255, 20'hFFFFF, 1, 1, 1, 1, 1));
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 255, 0, 0, 0, 0, 0, 1));
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 0, 20'hFFFFF, 0, 0, 0, 0, 1));
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 128, 0, 1, 0, 1, 0, 1));
        push_read(0);
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 77, 0, 1, 0, 1, 0, 0));
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 200, 0, 0, 1, 0, 0, 1));
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 200, 0, 1, 1, 1, 1, 1));
        for (int k = 0; k < 10; k++) begin
            item_q.push_back(mk_item(fas_pkg::CMD_DATA, 16 * k + 15, 0, k == 9, 0, 0, 1, 1));
        end
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 99, 0, 1, 0, 1, 0, 1));
        push_read(7);
        push_read(8);
        item_q.push_back(mk_item(fas_pkg::CMD_START, 0, 0, 0, 0, 0, 0, 0));
        push_read(0);

        configure(7, 0, 1);
        item_q.push_back(mk_item(fas_pkg::CMD_DATA, 255, 0, 1, 0, 1, 0, 1));
        push_read(0);
        item_q.push_back(mk_item(fas_pkg::CMD_START, 0, 0, 0, 0, 0, 0, 0));

        cap_len = TB_DEPTH + 10;
        configure(0, 1, fas_pkg::IMAGE_BYTES_RST);
        fill_random(260);

        cap_len = 4;
        configure(7, 65535, 1);
        fill_random(260);

        cap_len = 20;
        configure($urandom_range(1, 6), 3, 16);
        fill_random(260);

        img = $urandom_range(1, TB_DEPTH);
        cap_len = img + 4;
        configure($urandom_range(0, 7), $urandom_range(2, 5), img);
        fill_random(260);

        wait_idle();
        quiet <= 1'b1;
        cap_len = 12;
        configure(3, 4, TB_DEPTH);
        fill_random(260);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            errors++;
        end
        $display("Checked %0d results under %0d register settings: %0d frames summed,",
                 n_results, n_settings, n_frames);
        $display("%0d captures completed and %0d clears issued; %0d errors.",
                 n_captures, n_clears, errors);
        if (errors == 0) begin
            $display("frame_accumulator_shift_sum verification clean");
        end else begin
            $display("frame_accumulator_shift_sum verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fas_pkg.sv
rtl/fas_store.sv
rtl/frame_accumulator_shift_sum.sv
rtl/fas_checker.sv
tb/sv/frame_accumulator_shift_sum_tb.sv
